// ===== rtl/tqls_pkg.sv =====
// ----------------------------------------------------------------------------
// tqls_pkg
// Shared types and constants of the tabular Q-learning step unit: controller
// states, multiplier operations, configuration register codes, and the
// command and status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package tqls_pkg;

    // Q1.15 one, seven tenths in Q0.15, and the rounding half for a Q15 shift
    localparam logic [15:0] ONE_Q15          = 16'd32768;
    localparam logic [17:0] SEVEN_TENTHS_Q15 = 18'd22938;
    localparam int          ROUND_HALF_Q15   = 16384;

    // Joint indices come in as 3-bit fields
    localparam int IDX_SPAN = 8;

    // Configuration reset values
    localparam logic [15:0] LEARNING_RATE_RST   = 16'd3277;
    localparam logic [15:0] DISCOUNT_RST        = 16'd29491;
    localparam logic [31:0] PENALTY_OOR_RST     = 32'hFFF6_0000; // -10.0
    localparam logic [31:0] PENALTY_NO_MOVE_RST = 32'hFFFF_0000; // -1.0
    localparam logic [15:0] REWARD_FACTOR_RST   = 16'd256;

    typedef enum logic [2:0] {
        CFG_LEARNING_RATE   = 3'd0,
        CFG_DISCOUNT        = 3'd1,
        CFG_PENALTY_OOR     = 3'd2,
        CFG_PENALTY_NO_MOVE = 3'd3,
        CFG_REWARD_FACTOR   = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MUL_SCALE = 3'd0,   // displacement * displacement gain
        MUL_BACK  = 3'd1,   // scaled reward * 0.7
        MUL_DISC  = 3'd2,   // discount * best next value
        MUL_KEEP  = 3'd3,   // (one - lr) * old value
        MUL_BLEND = 3'd4    // lr * target
    } mul_op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCALE,
        ST_READ,
        ST_DRAIN,
        ST_DISC,
        ST_TARGET,
        ST_KEEP,
        ST_BLEND,
        ST_MIX
    } state_t;

    typedef struct packed {
        logic    load;          // capture request fields, restart read counter
        logic    mul_en;
        mul_op_t mul_op;
        logic    save_scaled;
        logic    save_reward;
        logic    rd_step;       // issue one table read
        logic    save_target;
        logic    save_acc;
        logic    commit;        // write table entry, load result register
        logic    clr_step;      // clear one table entry
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic rd_first;
        logic rd_second;
        logic rd_last;
    } dp_status_t;

endpackage

// ===== rtl/tqls_ram.sv =====
// ----------------------------------------------------------------------------
// tqls_ram
// Generic single-port RAM: one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
module tqls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tqls_ctrl.sv =====
// ----------------------------------------------------------------------------
// tqls_ctrl
// Controller: sequences the table clear, the reward multiplies, the table
// reads, the update arithmetic and the write-back; owns the result valid.
// ----------------------------------------------------------------------------
module tqls_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    output tqls_pkg::ctrl_cmd_t    cmd,
    input  tqls_pkg::dp_status_t   status
);

    import tqls_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // result slot can take a new result this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (status.clr_last) state_next = ST_IDLE;
            ST_IDLE:   if (in_valid) state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_READ;
            ST_READ:   if (status.rd_last) state_next = ST_DRAIN;
            ST_DRAIN:  state_next = ST_DISC;
            ST_DISC:   state_next = ST_TARGET;
            ST_TARGET: state_next = ST_KEEP;
            ST_KEEP:   state_next = ST_BLEND;
            ST_BLEND:  state_next = ST_MIX;
            ST_MIX:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.mul_op = MUL_SCALE;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.load = in_valid;
            end
            ST_SCALE:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_SCALE;
            end
            ST_READ:
            begin
                cmd.rd_step = 1'b1;
                // reward work overlaps the reads
                if (status.rd_first)
                begin
                    cmd.mul_en      = 1'b1;
                    cmd.mul_op      = MUL_BACK;
                    cmd.save_scaled = 1'b1;
                end
                if (status.rd_second)
                begin
                    cmd.save_reward = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                cmd = '0;
            end
            ST_DISC:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_DISC;
            end
            ST_TARGET:
            begin
                cmd.save_target = 1'b1;
            end
            ST_KEEP:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_KEEP;
            end
            ST_BLEND:
            begin
                cmd.save_acc = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_op   = MUL_BLEND;
            end
            ST_MIX:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/tqls_dpath.sv =====
// ----------------------------------------------------------------------------
// tqls_dpath
// Datapath: configuration registers, index clamping, the value table, the
// arg-max scan, one shared signed multiplier and the rounding, blending and
// saturation of the new value.
// ----------------------------------------------------------------------------
module tqls_dpath #(
    parameter int HIP_STEPS    = 8,
    parameter int KNEE_STEPS   = 8,
    parameter int ACTION_COUNT = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tqls_pkg::ctrl_cmd_t    cmd,
    output tqls_pkg::dp_status_t   status,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    input  logic [2:0]             hip_a_index,
    input  logic [2:0]             knee_a_index,
    input  logic [2:0]             hip_b_index,
    input  logic [2:0]             knee_b_index,
    input  logic [2:0]             taken_action,
    input  logic                   aborted,
    input  logic signed [15:0]     displacement,
    input  logic [2:0]             next_hip_a,
    input  logic [2:0]             next_knee_a,
    input  logic [2:0]             next_hip_b,
    input  logic [2:0]             next_knee_b,
    output logic [2:0]             best_action,
    output logic signed [31:0]     reward_value,
    output logic signed [31:0]     updated_value
);

    import tqls_pkg::*;

    localparam int HIP_LIM  = (HIP_STEPS > IDX_SPAN) ? IDX_SPAN : HIP_STEPS;
    localparam int KNEE_LIM = (KNEE_STEPS > IDX_SPAN) ? IDX_SPAN : KNEE_STEPS;
    localparam int HIP_W    = $clog2(HIP_LIM);
    localparam int KNEE_W   = $clog2(KNEE_LIM);
    localparam int ACT_W    = $clog2(ACTION_COUNT);
    localparam int ADDR_W   = 2 * HIP_W + 2 * KNEE_W + ACT_W;
    localparam int BASE_W   = ADDR_W - ACT_W;
    localparam int DEPTH    = 1 << ADDR_W;
    localparam int CNT_W    = ACT_W + 1;

    function automatic logic [3:0] clamp_idx(input logic [2:0] v, input int n);
        logic [4:0] lim;
        lim = 5'(n);
        return ({2'b00, v} >= lim) ? 4'(lim - 5'd1) : {1'b0, v};
    endfunction

    // configuration
    logic [15:0]        lr_reg;
    logic [15:0]        disc_reg;
    logic signed [31:0] pen_oor_reg;
    logic signed [31:0] pen_nm_reg;
    logic [15:0]        factor_reg;
    logic [15:0]        lr_eff;
    logic [15:0]        disc_eff;
    logic [15:0]        keep_w;

    // request
    logic [3:0]         c_ha, c_ka, c_hb, c_kb, c_act;
    logic [3:0]         n_ha, n_ka, n_hb, n_kb;
    logic [ADDR_W-1:0]  cur_addr_reg;
    logic [BASE_W-1:0]  next_base_reg;
    logic               aborted_reg;
    logic signed [15:0] disp_reg;

    // table access
    logic [ADDR_W-1:0]  clr_cnt_reg;
    logic [CNT_W-1:0]   rd_cnt_reg;
    logic               rd_pend_reg;
    logic               rd_old_reg;
    logic [ACT_W-1:0]   rd_act_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  ram_addr;
    logic [31:0]        ram_wdata;
    logic [31:0]        ram_rdata;
    logic signed [31:0] rd_val;

    // scan and arithmetic
    logic signed [31:0] best_val_reg;
    logic [ACT_W-1:0]   best_act_reg;
    logic signed [31:0] q_old_reg;
    logic signed [33:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [51:0] prod_next;
    logic signed [51:0] prod_reg;
    logic signed [31:0] scaled_reg;
    logic signed [31:0] reward_next;
    logic signed [31:0] reward_reg;
    logic signed [51:0] prod_rnd;
    logic signed [33:0] disc_term;
    logic signed [33:0] target_reg;
    logic signed [51:0] acc_reg;
    logic signed [52:0] mix_sum;
    logic signed [37:0] mix_q;
    logic signed [31:0] mix_sat;

    // output register
    logic [2:0]         best_out_reg;
    logic signed [31:0] reward_out_reg;
    logic signed [31:0] upd_out_reg;

    // clamp rates above one to one
    assign lr_eff   = (lr_reg > ONE_Q15) ? ONE_Q15 : lr_reg;
    assign disc_eff = (disc_reg > ONE_Q15) ? ONE_Q15 : disc_reg;
    assign keep_w   = ONE_Q15 - lr_eff;

    assign c_ha  = clamp_idx(hip_a_index, HIP_STEPS);
    assign c_ka  = clamp_idx(knee_a_index, KNEE_STEPS);
    assign c_hb  = clamp_idx(hip_b_index, HIP_STEPS);
    assign c_kb  = clamp_idx(knee_b_index, KNEE_STEPS);
    assign c_act = clamp_idx(taken_action, ACTION_COUNT);
    assign n_ha  = clamp_idx(next_hip_a, HIP_STEPS);
    assign n_ka  = clamp_idx(next_knee_a, KNEE_STEPS);
    assign n_hb  = clamp_idx(next_hip_b, HIP_STEPS);
    assign n_kb  = clamp_idx(next_knee_b, KNEE_STEPS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg      <= LEARNING_RATE_RST;
            disc_reg    <= DISCOUNT_RST;
            pen_oor_reg <= PENALTY_OOR_RST;
            pen_nm_reg  <= PENALTY_NO_MOVE_RST;
            factor_reg  <= REWARD_FACTOR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEARNING_RATE:   lr_reg      <= cfg_data[15:0];
                CFG_DISCOUNT:        disc_reg    <= cfg_data[15:0];
                CFG_PENALTY_OOR:     pen_oor_reg <= cfg_data;
                CFG_PENALTY_NO_MOVE: pen_nm_reg  <= cfg_data;
                CFG_REWARD_FACTOR:   factor_reg  <= cfg_data[15:0];
                default:             lr_reg      <= lr_reg;
            endcase
        end
    end

    // table address selection: clear sweep, write-back, or scan read
    assign rd_addr = (rd_cnt_reg < CNT_W'(ACTION_COUNT))
                   ? {next_base_reg, rd_cnt_reg[ACT_W-1:0]} : cur_addr_reg;
    assign ram_addr  = cmd.clr_step ? clr_cnt_reg : (cmd.commit ? cur_addr_reg : rd_addr);
    assign ram_wdata = cmd.clr_step ? 32'd0 : mix_sat;

    tqls_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.clr_step || cmd.commit),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_val = ram_rdata;

    assign status.clr_last  = &clr_cnt_reg;
    assign status.rd_first  = (rd_cnt_reg == '0);
    assign status.rd_second = (rd_cnt_reg == CNT_W'(1));
    assign status.rd_last   = (rd_cnt_reg == CNT_W'(ACTION_COUNT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            rd_cnt_reg  <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.load)
            begin
                rd_cnt_reg <= '0;
            end
            else if (cmd.rd_step)
            begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
            rd_pend_reg <= cmd.rd_step;
        end
    end

    // shared multiplier operand selection
    always_comb
    begin
        mul_a = 34'(disp_reg);
        mul_b = signed'({2'b00, factor_reg});
        unique case (cmd.mul_op)
            MUL_SCALE:
            begin
                mul_a = 34'(disp_reg);
                mul_b = signed'({2'b00, factor_reg});
            end
            MUL_BACK:
            begin
                mul_a = 34'(signed'(prod_reg[31:0]));
                mul_b = signed'(SEVEN_TENTHS_Q15);
            end
            MUL_DISC:
            begin
                mul_a = 34'(best_val_reg);
                mul_b = signed'({2'b00, disc_eff});
            end
            MUL_KEEP:
            begin
                mul_a = 34'(q_old_reg);
                mul_b = signed'({2'b00, keep_w});
            end
            MUL_BLEND:
            begin
                mul_a = target_reg;
                mul_b = signed'({2'b00, lr_eff});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // round to nearest with halves up, then drop 15 fraction bits
    assign prod_rnd = prod_reg + 52'(ROUND_HALF_Q15);

    always_comb
    begin
        priority if (aborted_reg)
        begin
            reward_next = pen_oor_reg;
        end
        else if (disp_reg == '0)
        begin
            reward_next = pen_nm_reg;
        end
        else if (!disp_reg[15])
        begin
            reward_next = scaled_reg;
        end
        else
        begin
            reward_next = signed'(prod_rnd[46:15]);
        end
    end

    assign disc_term = signed'(prod_rnd[48:15]);
    assign mix_sum   = 53'(acc_reg) + 53'(prod_reg) + 53'(ROUND_HALF_Q15);
    assign mix_q     = mix_sum[52:15];

    always_comb
    begin
        priority if (mix_q > 38'sd2147483647)
        begin
            mix_sat = 32'sh7FFF_FFFF;
        end
        else if (mix_q < -38'sd2147483648)
        begin
            mix_sat = 32'sh8000_0000;
        end
        else
        begin
            mix_sat = mix_q[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_addr_reg  <= {c_ha[HIP_W-1:0], c_ka[KNEE_W-1:0],
                              c_hb[HIP_W-1:0], c_kb[KNEE_W-1:0], c_act[ACT_W-1:0]};
            next_base_reg <= {n_ha[HIP_W-1:0], n_ka[KNEE_W-1:0],
                              n_hb[HIP_W-1:0], n_kb[KNEE_W-1:0]};
            aborted_reg   <= aborted;
            disp_reg      <= displacement;
        end
        if (cmd.rd_step)
        begin
            rd_old_reg <= status.rd_last;
            rd_act_reg <= rd_cnt_reg[ACT_W-1:0];
        end
        // scan: first action seeds the maximum, later ones replace only if greater
        if (rd_pend_reg)
        begin
            if (rd_old_reg)
            begin
                q_old_reg <= rd_val;
            end
            else if (rd_act_reg == '0 || rd_val > best_val_reg)
            begin
                best_val_reg <= rd_val;
                best_act_reg <= rd_act_reg;
            end
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.save_scaled)
        begin
            scaled_reg <= prod_reg[31:0];
        end
        if (cmd.save_reward)
        begin
            reward_reg <= reward_next;
        end
        if (cmd.save_target)
        begin
            target_reg <= 34'(reward_reg) + disc_term;
        end
        if (cmd.save_acc)
        begin
            acc_reg <= prod_reg;
        end
        if (cmd.commit)
        begin
            best_out_reg   <= 3'(best_act_reg);
            reward_out_reg <= reward_reg;
            upd_out_reg    <= mix_sat;
        end
    end

    assign best_action   = best_out_reg;
    assign reward_value  = reward_out_reg;
    assign updated_value = upd_out_reg;

endmodule

// ===== rtl/tabular_q_learning_step_unit.sv =====
// ----------------------------------------------------------------------------
// tabular_q_learning_step_unit
// One request at a time: in_stall stays high from acceptance until the
// result is committed, and the next request can be taken in the cycle the
// result first shows. The single table port is read once per action of the
// next state plus once for the old value, and one multiplier is shared by
// all products.
// Reset: the whole table, 2**(table address bits) entries (32768 at default
// sizes), is cleared with in_stall high; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module tabular_q_learning_step_unit #(
    parameter int HIP_STEPS    = 8,
    parameter int KNEE_STEPS   = 8,
    parameter int ACTION_COUNT = 8
) (
    input  logic               clk,
    input  logic               rst_n,

    // request channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         hip_a_index,
    input  logic [2:0]         knee_a_index,
    input  logic [2:0]         hip_b_index,
    input  logic [2:0]         knee_b_index,
    input  logic [2:0]         taken_action,
    input  logic               aborted,
    input  logic signed [15:0] displacement,
    input  logic [2:0]         next_hip_a,
    input  logic [2:0]         next_knee_a,
    input  logic [2:0]         next_hip_b,
    input  logic [2:0]         next_knee_b,

    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         best_action,
    output logic signed [31:0] reward_value,
    output logic signed [31:0] updated_value,

    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    import tqls_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Configuration registers are plain flops; always take the write.
    assign cfg_ready = 1'b1;

    // Controller: walks each request through
    //   accept -> scale displacement -> read next-state actions and old value
    //   (0.7 backward scaling and reward choice overlap the reads) -> drain
    //   -> discount best value -> form target -> weigh old value -> weigh
    //   target -> blend, saturate, write back and hand over the result.
    // The write-back waits in the last step while a previous result is still
    // held by a stalled consumer, so no result is ever dropped.
    tqls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // Datapath: owns the value table, the arg-max scan (lowest action wins
    // ties, since later actions replace only on strictly greater values),
    // the shared multiplier and the result register. Reads all happen before
    // the single write, so a next state that aliases the written entry sees
    // the old value.
    tqls_dpath #(
        .HIP_STEPS    (HIP_STEPS),
        .KNEE_STEPS   (KNEE_STEPS),
        .ACTION_COUNT (ACTION_COUNT)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .hip_a_index   (hip_a_index),
        .knee_a_index  (knee_a_index),
        .hip_b_index   (hip_b_index),
        .knee_b_index  (knee_b_index),
        .taken_action  (taken_action),
        .aborted       (aborted),
        .displacement  (displacement),
        .next_hip_a    (next_hip_a),
        .next_knee_a   (next_knee_a),
        .next_hip_b    (next_hip_b),
        .next_knee_b   (next_knee_b),
        .best_action   (best_action),
        .reward_value  (reward_value),
        .updated_value (updated_value)
    );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tabular Q-learning step unit. It keeps its own
// copy of the value table and the five settings, and computes reward, best
// next action and new table value for every accepted request. Directed
// requests cover the field extremes and the corner cases; random traffic
// under several settings follows. Both channels pause and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import tqls_pkg::*;

    localparam int     CLK_PERIOD   = 12;
    localparam int     HIP_STEPS    = 8;
    localparam int     KNEE_STEPS   = 8;
    localparam int     ACTION_COUNT = 8;
    localparam int     TABLE_DEPTH  = HIP_STEPS * KNEE_STEPS * HIP_STEPS * KNEE_STEPS
                                      * ACTION_COUNT;
    localparam longint UNITY_Q15    = 32768;
    localparam longint SEVEN_TENTHS = 22938;
    localparam longint Q_MAX        = 2147483647;
    localparam longint Q_MIN        = -longint'(2147483647) - 1;
    // The limit must cover the table clearing after reset; the rest is traffic
    localparam longint LIMIT_CYCLES = 400000;
    localparam int     RANDOM_PHASES    = 6;
    localparam int     ITEMS_PER_PHASE  = 125;

    typedef struct {
        logic [2:0]         hip_a;
        logic [2:0]         knee_a;
        logic [2:0]         hip_b;
        logic [2:0]         knee_b;
        logic [2:0]         action;
        logic               aborted;
        logic signed [15:0] disp;
        logic [2:0]         next_hip_a;
        logic [2:0]         next_knee_a;
        logic [2:0]         next_hip_b;
        logic [2:0]         next_knee_b;
    } step_req_t;

    typedef struct {
        logic [2:0]         best;
        logic signed [31:0] reward;
        logic signed [31:0] value;
    } step_res_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         hip_a_index;
    logic [2:0]         knee_a_index;
    logic [2:0]         hip_b_index;
    logic [2:0]         knee_b_index;
    logic [2:0]         taken_action;
    logic               aborted;
    logic signed [15:0] displacement;
    logic [2:0]         next_hip_a;
    logic [2:0]         next_knee_a;
    logic [2:0]         next_hip_b;
    logic [2:0]         next_knee_b;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         best_action;
    logic signed [31:0] reward_value;
    logic signed [31:0] updated_value;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    // Shadow of the block: settings and action-value table
    logic [15:0]        rate_q15;
    logic [15:0]        discount_q15;
    logic signed [31:0] penalty_abort;
    logic signed [31:0] penalty_still;
    logic [15:0]        gain_q8;
    int                 q_table [TABLE_DEPTH];

    step_res_t          pending_results[$];
    int                 fail_count;
    int                 results_seen;
    int                 send_burst;
    int                 recv_burst;

    tabular_q_learning_step_unit #(
        .HIP_STEPS    (HIP_STEPS),
        .KNEE_STEPS   (KNEE_STEPS),
        .ACTION_COUNT (ACTION_COUNT)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .hip_a_index   (hip_a_index),
        .knee_a_index  (knee_a_index),
        .hip_b_index   (hip_b_index),
        .knee_b_index  (knee_b_index),
        .taken_action  (taken_action),
        .aborted       (aborted),
        .displacement  (displacement),
        .next_hip_a    (next_hip_a),
        .next_knee_a   (next_knee_a),
        .next_hip_b    (next_hip_b),
        .next_knee_b   (next_knee_b),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .best_action   (best_action),
        .reward_value  (reward_value),
        .updated_value (updated_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow arithmetic
    // ------------------------------------------------------------------------

    // Divide by 2^15, rounding to nearest with halves toward plus infinity
    function automatic longint round_q15(input longint x);
        return (x + 16384) >>> 15;
    endfunction

    // Out-of-range steps saturate to the last one
    function automatic int clamp_step(input logic [2:0] v, input int n);
        return (int'(v) >= n) ? n - 1 : int'(v);
    endfunction

    function automatic int table_base(input logic [2:0] ha, input logic [2:0] ka,
                                      input logic [2:0] hb, input logic [2:0] kb);
        return (((clamp_step(ha, HIP_STEPS) * KNEE_STEPS + clamp_step(ka, KNEE_STEPS))
                 * HIP_STEPS + clamp_step(hb, HIP_STEPS)) * KNEE_STEPS
                + clamp_step(kb, KNEE_STEPS)) * ACTION_COUNT;
    endfunction

    // Work out the result of one request and commit the new value to the table
    function automatic step_res_t predict_update(input step_req_t r);
        int        cur;
        int        nxt;
        int        act;
        int        best_val;
        longint    lr;
        longint    df;
        longint    reward;
        longint    target;
        longint    mix;
        longint    q_old;
        step_res_t res;
        cur = table_base(r.hip_a, r.knee_a, r.hip_b, r.knee_b);
        nxt = table_base(r.next_hip_a, r.next_knee_a, r.next_hip_b, r.next_knee_b);
        act = clamp_step(r.action, ACTION_COUNT);
        // Rates above one act as one
        lr = (rate_q15 > UNITY_Q15) ? UNITY_Q15 : longint'(rate_q15);
        df = (discount_q15 > UNITY_Q15) ? UNITY_Q15 : longint'(discount_q15);

        if (r.aborted)
            reward = penalty_abort;
        else if (r.disp == 0)
            reward = penalty_still;
        else if (r.disp > 0)
            reward = longint'(r.disp) * longint'(gain_q8);
        else
            reward = round_q15(longint'(r.disp) * longint'(gain_q8) * SEVEN_TENTHS);

        // Arg-max of the next state, lowest action wins a tie; read before write
        res.best = '0;
        best_val = q_table[nxt];
        for (int a = 1; a < ACTION_COUNT; a++)
        begin
            if (q_table[nxt + a] > best_val)
            begin
                best_val = q_table[nxt + a];
                res.best = 3'(a);
            end
        end
        q_old = q_table[cur + act];

        target = reward + round_q15(df * longint'(best_val));
        mix = round_q15((UNITY_Q15 - lr) * q_old + lr * target);
        if (mix > Q_MAX)
            mix = Q_MAX;
        if (mix < Q_MIN)
            mix = Q_MIN;
        q_table[cur + act] = int'(mix);

        res.reward = reward[31:0];
        res.value  = mix[31:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Channel helpers
    // ------------------------------------------------------------------------

    // Pause length for one request or result: mostly 0..14, now and then a
    // run of back-to-back transfers with no pause at all
    function automatic int draw_pause(inout int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            burst_left = $urandom_range(4, 24);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic step_req_t request_of(input logic [11:0] from_state,
                                             input logic [2:0] act, input logic abrt,
                                             input logic signed [15:0] disp,
                                             input logic [11:0] to_state);
        step_req_t r;
        {r.hip_a, r.knee_a, r.hip_b, r.knee_b} = from_state;
        r.action  = act;
        r.aborted = abrt;
        r.disp    = disp;
        {r.next_hip_a, r.next_knee_a, r.next_hip_b, r.next_knee_b} = to_state;
        return r;
    endfunction

    // Write one setting while the block is idle; mirror it into the shadow
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_LEARNING_RATE:   rate_q15      = data[15:0];
            CFG_DISCOUNT:        discount_q15  = data[15:0];
            CFG_PENALTY_OOR:     penalty_abort = data;
            CFG_PENALTY_NO_MOVE: penalty_still = data;
            CFG_REWARD_FACTOR:   gain_q8       = data[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Send one request: hold it until accepted, then log its expected result.
    // Returns in the time step of the accepting edge.
    task automatic push_request(input step_req_t r);
        int pause;
        pause = draw_pause(send_burst);
        @(negedge clk);
        if (pause > 0)
        begin
            in_valid <= 1'b0;
            repeat (pause) @(negedge clk);
        end
        hip_a_index  <= r.hip_a;
        knee_a_index <= r.knee_a;
        hip_b_index  <= r.hip_b;
        knee_b_index <= r.knee_b;
        taken_action <= r.action;
        aborted      <= r.aborted;
        displacement <= r.disp;
        next_hip_a   <= r.next_hip_a;
        next_knee_a  <= r.next_knee_a;
        next_hip_b   <= r.next_hip_b;
        next_knee_b  <= r.next_knee_b;
        in_valid     <= 1'b1;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(predict_update(r));
    endtask

    // Drop valid right after the last accepted request, then drain results
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("result %0d: %s mismatch, got %h, want %h",
                 results_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls and the checker
    // ------------------------------------------------------------------------

    // Stall each result for a drawn number of cycles once it shows up;
    // raise the stall ahead of time so it actually lands on a valid result
    initial
    begin
        int pause;
        out_stall = 1'b0;
        forever
        begin
            pause = draw_pause(recv_burst);
            @(negedge clk);
            out_stall <= (pause != 0);
            if (pause != 0)
            begin
                do @(posedge clk); while (!out_valid);
                repeat (pause) @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // Compare every accepted result with the oldest pending expectation
    always @(posedge clk)
    begin
        step_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("unrequested result", updated_value, '0);
            else
            begin
                want = pending_results.pop_front();
                if (best_action !== want.best)
                    report_mismatch("best_action", 32'(best_action),
                                    32'(want.best));
                if (reward_value !== want.reward)
                    report_mismatch("reward_value", reward_value, want.reward);
                if (updated_value !== want.value)
                    report_mismatch("updated_value", updated_value, want.value);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings: field extremes, abort, no motion, aliasing, ties
    task automatic test_reset_settings();
        // Next entry is the one being written: the old value must be used
        push_request(request_of(12'o0000, 3'd0, 1'b0, 16'sd256, 12'o0000));
        push_request(request_of(12'o7777, 3'd7, 1'b0, 16'sh7FFF, 12'o7777));
        // Largest backward step goes through the 0.7 scale
        push_request(request_of(12'o7777, 3'd3, 1'b0, 16'sh8000, 12'o0000));
        push_request(request_of(12'o7777, 3'd5, 1'b0, -16'sd1, 12'o7777));
        push_request(request_of(12'o1234, 3'd1, 1'b0, 16'sd1, 12'o7777));
        push_request(request_of(12'o1234, 3'd2, 1'b0, 16'sd0, 12'o0000));
        // Abort wins over any displacement, zero included
        push_request(request_of(12'o4321, 3'd4, 1'b1, 16'sh7FFF, 12'o1234));
        push_request(request_of(12'o4321, 3'd6, 1'b1, 16'sd0, 12'o4321));
        // Two equal values in one state: the lower action must win the tie
        push_request(request_of(12'o2222, 3'd5, 1'b0, 16'sd256, 12'o0000));
        push_request(request_of(12'o2222, 3'd6, 1'b0, 16'sd256, 12'o0000));
        push_request(request_of(12'o3333, 3'd0, 1'b0, 16'sd100, 12'o2222));
        // Sweep every action of one state with mixed rewards
        for (int a = 0; a < ACTION_COUNT; a++)
            push_request(request_of(12'o5555, 3'(a), 1'b0 ^ (a == 6), 16'(a * 96 - 384),
                                    12'o5555));
        push_request(request_of(12'o0707, 3'd2, 1'b0, 16'sd1, 12'o5555));
        settle();
    endtask

    // Settings at their limits: rates of one and above, zero rates,
    // extreme penalties and gains, saturation both ways
    task automatic test_setting_extremes();
        write_reg(CFG_LEARNING_RATE, 32'd32768);
        write_reg(CFG_DISCOUNT, 32'd32768);
        write_reg(CFG_REWARD_FACTOR, 32'h0000_FFFF);
        // Largest reward, then a bootstrap that overflows to the top rail
        push_request(request_of(12'o3030, 3'd0, 1'b0, 16'sh7FFF, 12'o3030));
        push_request(request_of(12'o3030, 3'd1, 1'b0, 16'sh7FFF, 12'o3030));
        push_request(request_of(12'o3030, 3'd1, 1'b0, 16'sh7FFF, 12'o3030));
        push_request(request_of(12'o3131, 3'd0, 1'b0, 16'sh8000, 12'o3131));
        settle();

        // Fill a state with the most negative value, then push below it
        write_reg(CFG_PENALTY_OOR, 32'h8000_0000);
        for (int a = 0; a <= ACTION_COUNT; a++)
            push_request(request_of(12'o6161, 3'(a), 1'b1, 16'(a * 3), 12'o6161));
        settle();

        write_reg(CFG_PENALTY_NO_MOVE, 32'h7FFF_FFFF);
        push_request(request_of(12'o6161, 3'd0, 1'b0, 16'sd0, 12'o3030));
        settle();
        write_reg(CFG_PENALTY_OOR, 32'h7FFF_FFFF);
        write_reg(CFG_PENALTY_NO_MOVE, 32'h8000_0000);
        push_request(request_of(12'o6262, 3'd0, 1'b1, 16'sd0, 12'o0000));
        push_request(request_of(12'o6262, 3'd1, 1'b0, 16'sd0, 12'o0000));
        settle();

        // Rates above one must behave as one; zero gain kills motion rewards
        write_reg(CFG_LEARNING_RATE, 32'h0000_FFFF);
        write_reg(CFG_DISCOUNT, 32'h0000_FFFF);
        write_reg(CFG_REWARD_FACTOR, 32'd0);
        push_request(request_of(12'o3030, 3'd2, 1'b0, 16'sd500, 12'o3030));
        push_request(request_of(12'o3030, 3'd3, 1'b0, -16'sd500, 12'o3030));
        settle();

        // Zero learning rate: the stored value must not move
        write_reg(CFG_LEARNING_RATE, 32'd0);
        write_reg(CFG_DISCOUNT, 32'd0);
        write_reg(CFG_REWARD_FACTOR, 32'd256);
        push_request(request_of(12'o3030, 3'd1, 1'b0, 16'sd300, 12'o6161));
        settle();

        // Writes to unused indexes must leave every setting alone
        for (int i = int'(CFG_REWARD_FACTOR) + 1; i < 8; i++)
            write_reg(3'(i), $urandom);
        write_reg(CFG_LEARNING_RATE, 32'd16384);
        write_reg(CFG_DISCOUNT, 32'd16384);
        push_request(request_of(12'o1111, 3'd4, 1'b0, 16'sd999, 12'o3030));
        settle();
    endtask

    // One random set of all five registers, extremes drawn now and then
    task automatic randomize_settings();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = 32'd32768;
            1:       v = $urandom_range(32769, 65535);
            2:       v = 32'd0;
            default: v = $urandom_range(1, 32767);
        endcase
        write_reg(CFG_LEARNING_RATE, v);
        case ($urandom_range(0, 5))
            0:       v = 32'd32768;
            1:       v = $urandom_range(32769, 65535);
            2:       v = 32'd0;
            default: v = $urandom_range(1, 32767);
        endcase
        write_reg(CFG_DISCOUNT, v);
        v = ($urandom_range(0, 3) == 0) ? $urandom : -($urandom_range(0, 40) << 16);
        write_reg(CFG_PENALTY_OOR, v);
        v = ($urandom_range(0, 3) == 0) ? $urandom : -($urandom_range(0, 8) << 15);
        write_reg(CFG_PENALTY_NO_MOVE, v);
        case ($urandom_range(0, 5))
            0:       v = 32'h0000_FFFF;
            1:       v = $urandom_range(0, 65535);
            default: v = $urandom_range(0, 1024);
        endcase
        write_reg(CFG_REWARD_FACTOR, v);
    endtask

    // Most requests move among four states so table entries get revisited and
    // the arg-max sees real values; the rest roam the whole state space
    function automatic step_req_t random_request();
        step_req_t r;
        logic      narrow;
        narrow = ($urandom_range(0, 9) < 7);
        r.hip_a       = narrow ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7));
        r.knee_a      = narrow ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7));
        r.hip_b       = narrow ? 3'd0 : 3'($urandom_range(0, 7));
        r.knee_b      = narrow ? 3'd0 : 3'($urandom_range(0, 7));
        r.next_hip_a  = narrow ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7));
        r.next_knee_a = narrow ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7));
        r.next_hip_b  = narrow ? 3'd0 : 3'($urandom_range(0, 7));
        r.next_knee_b = narrow ? 3'd0 : 3'($urandom_range(0, 7));
        r.action      = 3'($urandom_range(0, 7));
        r.aborted     = ($urandom_range(0, 7) == 0);
        case ($urandom_range(0, 9))
            0:       r.disp = 16'sd0;
            1:       r.disp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2, 3, 4, 5:
                     r.disp = 16'($urandom_range(0, 2048)) - 16'sd1024;
            default: r.disp = 16'($urandom);
        endcase
        return r;
    endfunction

    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            randomize_settings();
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                push_request(random_request());
            settle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // Drive every input to a known value before anything else happens
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        hip_a_index   = '0;
        knee_a_index  = '0;
        hip_b_index   = '0;
        knee_b_index  = '0;
        taken_action  = '0;
        aborted       = 1'b0;
        displacement  = '0;
        next_hip_a    = '0;
        next_knee_a   = '0;
        next_hip_b    = '0;
        next_knee_b   = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        // Shadow settings start at the reset values; the table starts cleared
        rate_q15      = 16'd3277;
        discount_q15  = 16'd29491;
        penalty_abort = -32'sd655360;
        penalty_still = -32'sd65536;
        gain_q8       = 16'd256;
        fail_count    = 0;
        results_seen  = 0;
        send_burst    = 0;
        recv_burst    = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The table clear runs with in_stall high; the first request waits it out
        test_reset_settings();
        test_setting_extremes();
        test_random_traffic();

        // Everything drained; give a stray late result time to show up
        repeat (4 * (ACTION_COUNT + 9)) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hard stop if the handshakes hang
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("TB_ERROR");
        $finish;
    end

endmodule
